@@ src/cmm_pkg.sv @@
// cmm_pkg: shared constants, register indexes and state type for the
// complex magnitude multilook unit. No dependencies.
`default_nettype none
package cmm_pkg;
   localparam int MAX_COLUMNS = 4096;
   localparam int MAX_LOOKS   = 64;
   localparam int SAMPLE_BITS = 16;
   localparam int COL_BITS    = $clog2(MAX_COLUMNS);
   localparam int ROW_BITS    = $clog2(MAX_LOOKS);
   localparam int WIDTH_BITS  = 13;
   localparam int LOOK_BITS   = 7;
   localparam int SUM_BITS    = 22;
   localparam int MAG_BITS    = 16;
   localparam int SQ_BITS     = 2 * SAMPLE_BITS;

   localparam logic [WIDTH_BITS-1:0] LINE_WIDTH_RESET = WIDTH_BITS'(1024);
   localparam logic [LOOK_BITS-1:0]  LOOK_COUNT_RESET = LOOK_BITS'(1);
   localparam logic [SUM_BITS-1:0]   SUM_MAX          = {SUM_BITS{1'b1}};

   localparam logic REG_LINE_WIDTH = 1'b0;
   localparam logic REG_LOOK_COUNT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ADD,
      ST_ROOT,
      ST_MERGE,
      ST_DIV,
      ST_OUT
   } state_type;
endpackage
`default_nettype wire

@@ src/cmm_ram.sv @@
// cmm_ram: generic single-write, single-read synchronous RAM with a
// registered read port. No dependencies.
`default_nettype none
module cmm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire [WIDTH-1:0]          wr_data,
   input  wire                      rd_en,
   input  wire [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

@@ src/cmm_isqrt.sv @@
// cmm_isqrt: iterative integer square root, one result bit per cycle.
// Depends on cmm_pkg.
`default_nettype none
module cmm_isqrt import cmm_pkg::*; (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 start,
   input  wire [SQ_BITS-1:0]   radicand,
   output logic                done,
   output logic [MAG_BITS-1:0] root
);
   localparam int STEPS = SQ_BITS / 2;
   localparam int CNT_BITS = $clog2(STEPS + 1);

   logic [SQ_BITS-1:0]  rem_ff, rem_in;
   logic [SQ_BITS-1:0]  root_ff, root_in;
   logic [SQ_BITS-1:0]  bit_ff, bit_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                run_ff, run_in;
   logic                done_ff, done_in;
   logic [SQ_BITS:0]    trial;

   always_comb begin
      rem_in  = rem_ff;
      root_in = root_ff;
      bit_in  = bit_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {1'b0, root_ff} + {1'b0, bit_ff};
      if (start) begin
         rem_in  = radicand;
         root_in = '0;
         bit_in  = SQ_BITS'(1) << (SQ_BITS - 2);
         cnt_in  = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         if ({1'b0, rem_ff} >= trial) begin
            rem_in  = SQ_BITS'({1'b0, rem_ff} - trial);
            root_in = (root_ff >> 1) + bit_ff;
         end else begin
            root_in = root_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff + CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff[MAG_BITS-1:0];
endmodule
`default_nettype wire

@@ src/cmm_div.sv @@
// cmm_div: restoring divider of a column sum by the look count, one
// quotient bit per cycle. Depends on cmm_pkg.
`default_nettype none
module cmm_div import cmm_pkg::*; (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   input  wire [SUM_BITS-1:0]   dividend,
   input  wire [LOOK_BITS-1:0]  divisor,
   output logic                 done,
   output logic [SUM_BITS-1:0]  quotient
);
   localparam int CNT_BITS = $clog2(SUM_BITS + 1);

   logic [SUM_BITS-1:0]  quo_ff, quo_in;
   logic [LOOK_BITS-1:0] rem_ff, rem_in;
   logic [LOOK_BITS-1:0] dsr_ff, dsr_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [LOOK_BITS:0]   trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[SUM_BITS-1]};
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = LOOK_BITS'(trial - {1'b0, dsr_ff});
            quo_in = {quo_ff[SUM_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial[LOOK_BITS-1:0];
            quo_in = {quo_ff[SUM_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(SUM_BITS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule
`default_nettype wire

@@ src/complex_magnitude_multilook_unit.sv @@
// complex_magnitude_multilook_unit: top level, sequencer and column sum store.
// Depends on cmm_pkg, cmm_ram, cmm_isqrt and cmm_div.
//
// Takes complex samples in raster order, forms floor(sqrt(re^2+im^2)) and
// accumulates it per column over look_count rows in a 4096-entry column sum
// RAM. On the last row of a group each sample yields floor(sum/look_count);
// otherwise it yields no transaction. One sample is worked at a time: a new
// sample is taken only after the last one has passed the square root stage
// (start, 16 bit-serial steps and done) and, when it produces a result, the
// divider (its 22 bit-serial steps and done) and the load of the output
// register, which waits for as long as a result still waiting on rsp_tready
// holds the output register. A finished result sits in the output register
// while the next sample is taken. The column sums need no clearing: the first
// row of a group overwrites them.
`default_nettype none
module complex_magnitude_multilook_unit import cmm_pkg::*; (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_tvalid,
   output logic                  req_tready,
   input  wire [31:0]            req_tdata,   // sample_real[15:0], sample_imag[31:16]
   input  wire                   req_tuser,   // frame_start
   output logic                  rsp_tvalid,
   input  wire                   rsp_tready,
   output logic [15:0]           rsp_tdata,   // magnitude_avg[15:0]
   output logic                  rsp_tlast,   // line_end
   input  wire                   csr_we,
   input  wire                   csr_index,
   input  wire [WIDTH_BITS-1:0]  csr_wdata
);
   state_type state_ff, state_in;

   logic [WIDTH_BITS-1:0] line_width_ff;
   logic [LOOK_BITS-1:0]  look_count_ff;
   logic [COL_BITS-1:0]   col_ff, col_in;
   logic [ROW_BITS-1:0]   row_ff, row_in;

   logic [SAMPLE_BITS-1:0] abs_re_ff, abs_im_ff;
   logic [SQ_BITS-1:0]     sq_re_ff, sq_im_ff;
   logic [COL_BITS-1:0]    cur_col_ff;
   logic                   first_row_ff, last_row_ff, last_col_ff;
   logic [LOOK_BITS-1:0]   looks_ff;

   logic [SUM_BITS-1:0]    sum;
   logic [SUM_BITS:0]      sum_raw;
   logic [SUM_BITS-1:0]    rd_sum;
   logic [SUM_BITS-1:0]    mem_rd_data;
   logic [MAG_BITS-1:0]    mag;
   logic                   root_done, div_done;
   logic [SUM_BITS-1:0]    quotient;
   logic [SQ_BITS-1:0]     radicand_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [MAG_BITS-1:0]    rsp_data_ff;
   logic                   rsp_last_ff;

   logic                   accept, root_start, div_start, load_out, mem_we, mem_re;
   logic [WIDTH_BITS-1:0]  eff_width;
   logic [LOOK_BITS-1:0]   eff_looks;
   logic [COL_BITS-1:0]    pos;
   logic [ROW_BITS-1:0]    row;
   logic                   last_col, last_row;
   logic [SAMPLE_BITS-1:0] in_re, in_im;

   assign accept = req_tvalid && req_tready;
   assign in_re  = req_tdata[15:0];
   assign in_im  = req_tdata[31:16];

   always_comb begin
      if (line_width_ff == '0) begin
         eff_width = WIDTH_BITS'(1);
      end else if (line_width_ff > WIDTH_BITS'(MAX_COLUMNS)) begin
         eff_width = WIDTH_BITS'(MAX_COLUMNS);
      end else begin
         eff_width = line_width_ff;
      end
      if (look_count_ff == '0) begin
         eff_looks = LOOK_BITS'(1);
      end else if (look_count_ff > LOOK_BITS'(MAX_LOOKS)) begin
         eff_looks = LOOK_BITS'(MAX_LOOKS);
      end else begin
         eff_looks = look_count_ff;
      end
      pos      = req_tuser ? '0 : col_ff;
      row      = req_tuser ? '0 : row_ff;
      last_col = ({1'b0, pos} + WIDTH_BITS'(1)) >= eff_width;
      last_row = ({1'b0, row} + LOOK_BITS'(1)) >= eff_looks;
      col_in   = col_ff;
      row_in   = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row + ROW_BITS'(1);
         end else begin
            col_in = pos + COL_BITS'(1);
            row_in = row;
         end
      end
   end

   // column sum merge: first row of a group overwrites
   assign rd_sum  = first_row_ff ? '0 : mem_rd_data;
   assign sum_raw = {1'b0, rd_sum} + {{(SUM_BITS-MAG_BITS+1){1'b0}}, mag};
   assign sum     = sum_raw[SUM_BITS] ? SUM_MAX : sum_raw[SUM_BITS-1:0];

   always_comb begin
      state_in     = state_ff;
      req_tready   = 1'b0;
      mem_re       = 1'b0;
      mem_we       = 1'b0;
      root_start   = 1'b0;
      div_start    = 1'b0;
      load_out     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            mem_re   = 1'b1;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            root_start = 1'b1;
            state_in   = ST_ROOT;
         end
         ST_ROOT: begin
            if (root_done) begin
               state_in = ST_MERGE;
            end
         end
         ST_MERGE: begin
            mem_we = 1'b1;
            if (last_row_ff) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               load_out     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         line_width_ff <= LINE_WIDTH_RESET;
         look_count_ff <= LOOK_COUNT_RESET;
         col_ff        <= '0;
         row_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               REG_LINE_WIDTH: line_width_ff <= csr_wdata;
               REG_LOOK_COUNT: look_count_ff <= csr_wdata[LOOK_BITS-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         abs_re_ff    <= in_re[SAMPLE_BITS-1] ? SAMPLE_BITS'(-in_re) : in_re;
         abs_im_ff    <= in_im[SAMPLE_BITS-1] ? SAMPLE_BITS'(-in_im) : in_im;
         cur_col_ff   <= pos;
         first_row_ff <= (row == '0);
         last_row_ff  <= last_row;
         last_col_ff  <= last_col;
         looks_ff     <= eff_looks;
      end
      if (state_ff == ST_SQUARE) begin
         sq_re_ff <= abs_re_ff * abs_re_ff;
         sq_im_ff <= abs_im_ff * abs_im_ff;
      end
      if (state_ff == ST_ADD) begin
         radicand_ff <= sq_re_ff + sq_im_ff;
      end
      if (load_out) begin
         rsp_data_ff <= (quotient > SUM_BITS'(16'hFFFF)) ? 16'hFFFF
                                                          : quotient[MAG_BITS-1:0];
         rsp_last_ff <= last_col_ff;
      end
   end

   cmm_ram #(
      .WIDTH (SUM_BITS),
      .DEPTH (MAX_COLUMNS)
   ) u_sums (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (cur_col_ff),
      .wr_data (sum),
      .rd_en   (mem_re),
      .rd_addr (cur_col_ff),
      .rd_data (mem_rd_data)
   );

   // start pulse is registered so that it reaches the square root together with the radicand
   logic root_start_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         root_start_ff <= 1'b0;
      end else begin
         root_start_ff <= root_start;
      end
   end

   cmm_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start_ff),
      .radicand (radicand_ff),
      .done     (root_done),
      .root     (mag)
   );

   cmm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum),
      .divisor  (looks_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_SQUARE)
      else $error("accepted transaction did not start");
   a_no_out_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MERGE && !last_row_ff) |=> state_ff == ST_IDLE)
      else $error("non-emitting transaction did not finish");
   a_root_range: assert property (@(posedge clock) disable iff (reset)
      root_done |-> mag <= 16'd46341)
      else $error("square root out of range");
   a_out_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff) == ST_OUT)
      else $error("result transaction without a division");
endmodule
`default_nettype wire

@@ verif/complex_magnitude_multilook_unit_tb.sv @@
// complex_magnitude_multilook_unit_tb: directed and random stream test of the
// magnitude multilook unit against an in-bench column sum predictor.
// Depends on cmm_pkg and the complex_magnitude_multilook_unit rtl.
`timescale 1ns / 100ps
module complex_magnitude_multilook_unit_tb import cmm_pkg::*; ();

   typedef struct packed {
      logic [15:0] magnitude;
      logic        line_end;
   } pixel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic [31:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tready = 1'b0;
   logic csr_we = 1'b0;
   logic csr_index = REG_LINE_WIDTH;
   logic [WIDTH_BITS-1:0] csr_wdata = '0;
   wire req_tready, rsp_tvalid, rsp_tlast;
   wire [15:0] rsp_tdata;

   complex_magnitude_multilook_unit uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // predictor state
   logic [SUM_BITS-1:0] col_sum [MAX_COLUMNS];
   int unsigned col_pos, row_pos, width_reg, looks_reg;
   pixel_type pending_pixels[$];
   int mismatches;
   int burst_left;
   int cur_width;
   int sent_items;

   function automatic int unsigned int_sqrt(input longint unsigned n);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root[31:0];
   endfunction

   task automatic predict_pixel(input logic signed [15:0] re, input logic signed [15:0] im,
                                input logic fs);
      longint signed r, i;
      longint unsigned sum, avg;
      int unsigned w, l, col, mag;
      logic last_col, last_row;
      w = (width_reg == 0) ? 1 : (width_reg > MAX_COLUMNS ? MAX_COLUMNS : width_reg);
      l = (looks_reg == 0) ? 1 : (looks_reg > MAX_LOOKS ? MAX_LOOKS : looks_reg);
      r = re;
      i = im;
      mag = int_sqrt(r * r + i * i);
      if (fs) begin
         col_pos = 0;
         row_pos = 0;
      end
      col = col_pos % MAX_COLUMNS;
      sum = (row_pos == 0) ? mag : col_sum[col] + mag;
      if (sum > SUM_MAX) sum = SUM_MAX;
      col_sum[col] = sum[SUM_BITS-1:0];
      last_col = (col_pos + 1) >= w;
      last_row = (row_pos + 1) >= l;
      if (last_row) begin
         avg = sum / l;
         if (avg > 65535) avg = 65535;
         pending_pixels.push_back('{magnitude: avg[15:0], line_end: last_col});
      end
      if (last_col) begin
         col_pos = 0;
         row_pos = last_row ? 0 : ((row_pos + 1) & 6'h3f);
      end else begin
         col_pos = (col_pos + 1) & 12'hfff;
      end
   endtask

   // result checker
   always @(posedge clock) begin
      pixel_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected transaction %h last %b", rsp_tdata, rsp_tlast);
         end else begin
            want = pending_pixels.pop_front();
            if (want.magnitude !== rsp_tdata || want.line_end !== rsp_tlast) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %h/%b actual %h/%b",
                           want.magnitude, want.line_end, rsp_tdata, rsp_tlast);
            end
         end
      end
   end

   // receiver stall pattern
   always @(negedge clock) begin
      int ph;
      ph = $urandom_range(0, 15);
      rsp_tready <= (ph < 11) || (ph == 15);
   end

   // valid stays high after the transaction; the next call or an idle phase drops it
   task automatic send_sample(input logic [15:0] re, input logic [15:0] im, input logic fs);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= {im, re};
      req_tuser <= fs;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_pixel(re, im, fs);
      sent_items++;
      @(negedge clock);
   endtask

   task automatic wait_drained;
      int guard;
      guard = 0;
      req_tvalid <= 1'b0;
      while (pending_pixels.size() != 0 && guard < 200000) begin
         @(negedge clock);
         guard++;
      end
      // a sample without result may still be in flight
      repeat (60) @(negedge clock);
   endtask

   task automatic write_reg(input logic idx, input int unsigned value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[WIDTH_BITS-1:0];
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == REG_LINE_WIDTH) width_reg = value & 13'h1fff;
      else looks_reg = value & 7'h7f;
      @(negedge clock);
   endtask

   task automatic set_geometry(input int unsigned w, input int unsigned l);
      wait_drained();
      write_reg(REG_LINE_WIDTH, w);
      write_reg(REG_LOOK_COUNT, l);
      cur_width = (w == 0) ? 1 : (w > MAX_COLUMNS ? MAX_COLUMNS : w);
   endtask

   function automatic logic [15:0] rand_part;
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'hffff;
         default: return 16'($urandom);
      endcase
   endfunction

   // whole frames keep every later row on written accumulators
   task automatic send_frame(input int rows);
      for (int r = 0; r < rows; r++)
         for (int c = 0; c < cur_width; c++)
            send_sample(rand_part(), rand_part(), (r == 0 && c == 0));
   endtask

   task automatic test_extremes;
      set_geometry(4, 1);
      send_sample(16'h8000, 16'h8000, 1'b1);
      send_sample(16'h7fff, 16'h7fff, 1'b0);
      send_sample(16'h0000, 16'h0000, 1'b0);
      send_sample(16'h8000, 16'h7fff, 1'b0);
      send_sample(16'hffff, 16'h0001, 1'b0);
      send_sample(16'h5555, 16'haaaa, 1'b0);
   endtask

   task automatic test_multilook_directed;
      set_geometry(3, 2);
      for (int k = 0; k < 6; k++) send_sample(16'h8000, 16'h8000, k == 0);
      // mid-group frame restart overwrites sums on the new first row
      send_sample(16'h0003, 16'h0004, 1'b1);
      send_sample(16'h0003, 16'h0004, 1'b1);
      for (int k = 0; k < 5; k++) send_sample(16'h7fff, 16'h0000, 1'b0);
   endtask

   task automatic test_register_limits;
      set_geometry(0, 0);
      send_sample(16'h1234, 16'h8000, 1'b1);
      send_sample(16'h0001, 16'h0001, 1'b0);
      set_geometry(13'h1fff, 7'h7f);
      send_sample(16'h0100, 16'h0100, 1'b1);
      set_geometry(1, 64);
      send_frame(64);
      set_geometry(2, 100);
      send_frame(64);
   endtask

   task automatic test_random_frames;
      int part_len;
      while (sent_items < 1450) begin
         set_geometry($urandom_range(1, 24), $urandom_range(1, 6));
         send_frame($urandom_range(1, 5));
         // truncated frame: partial trailing group emits nothing unless the look count is one
         if ($urandom_range(0, 3) == 0) begin
            part_len = $urandom_range(1, cur_width);
            for (int k = 0; k < part_len; k++)
               send_sample(rand_part(), rand_part(), k == 0);
         end
      end
   endtask

   initial begin
      mismatches = 0;
      burst_left = 0;
      sent_items = 0;
      col_pos = 0;
      row_pos = 0;
      width_reg = 1024;
      looks_reg = 1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_extremes();
      test_multilook_directed();
      test_register_limits();
      test_random_frames();
      wait_drained();
      if (mismatches == 0 && pending_pixels.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("tb: failure");
      $finish;
   end
endmodule
